[hdl/stbs_pkg.sv]
// Shared types and constants for the sorted table binary search block.
`timescale 1ns / 1ps
package stbs_pkg;

  localparam int KEY_W  = 32;
  localparam int PAY_W  = 32;
  localparam int IDX_W  = 4;
  localparam int SIZE_W = 5;
  localparam int BND_W  = 5;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic load;
    logic write;
    logic step;
    logic hit;
    logic miss;
  } dp_cmd_t;

  typedef struct packed {
    logic init_nonempty;
    logic step_nonempty;
    logic equal;
  } dp_status_t;

endpackage

[hdl/sorted_table_binary_search.sv]
// Top level of the sorted table binary search block.
`timescale 1ns / 1ps
// A request is taken when start_i is high and busy_o is low. A write request
// stores its key and payload and is acknowledged by done_o in the next
// cycle. A lookup request probes the table memory once per cycle, one
// binary search step each, with at most floor(log2(n)) + 1 probes for n
// active entries (five probes for sixteen); busy_o is high while the probes
// run and a new request may be given in the cycle that done_o is high. The
// result ports are valid from the cycle that done_o is high until the next
// request ends, and must be taken then: the block has no way to hold a
// result back.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [stbs_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 opcode_i,
  input  logic [stbs_pkg::IDX_W-1:0]           entry_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0]    search_key_i,
  input  logic [stbs_pkg::PAY_W-1:0]           entry_payload_i,
  output logic                                 done_o,
  output logic                                 found_o,
  output logic [stbs_pkg::PAY_W-1:0]           match_payload_o,
  output logic [stbs_pkg::IDX_W-1:0]           match_position_o
);

  stbs_pkg::dp_cmd_t    cmd;
  stbs_pkg::dp_status_t status;

  stbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .entry_index_i    (entry_index_i),
    .search_key_i     (search_key_i),
    .entry_payload_i  (entry_payload_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .found_o          (found_o),
    .match_payload_o  (match_payload_o),
    .match_position_o (match_position_o)
  );

endmodule

[hdl/stbs_ctrl.sv]
// Controller state machine: sequences writes and binary search probes.
`timescale 1ns / 1ps
module stbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 opcode_i,
  input  stbs_pkg::dp_status_t status_i,
  output stbs_pkg::dp_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PROBE = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (opcode_i == stbs_pkg::OP_LOOKUP) begin
            cmd_o.load = 1'b1;
            if (status_i.init_nonempty) begin
              state_d = S_PROBE;
            end else begin
              cmd_o.miss = 1'b1;
              done_d     = 1'b1;
            end
          end else begin
            cmd_o.write = 1'b1;
            cmd_o.miss  = 1'b1;
            done_d      = 1'b1;
          end
        end
      end
      S_PROBE: begin
        cmd_o.step = 1'b1;
        if (status_i.equal) begin
          cmd_o.hit = 1'b1;
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else if (!status_i.step_nonempty) begin
          cmd_o.miss = 1'b1;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q == S_PROBE);
  assign done_o = done_q;

  a_done_in_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe while a search is still running");

  a_write_ack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && opcode_i == stbs_pkg::OP_WRITE) |=> done_q)
    else $error("write request not acknowledged in the next cycle");

  a_hit_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && status_i.equal) |=> (done_q && state_q == S_IDLE))
    else $error("matching probe did not end the search");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.hit, cmd_o.miss}))
    else $error("hit and miss captured together");

endmodule

[hdl/stbs_datapath.sv]
// Datapath: table memory, size register, search bounds and result registers.
`timescale 1ns / 1ps
module stbs_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [stbs_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic [stbs_pkg::IDX_W-1:0]           entry_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0]    search_key_i,
  input  logic [stbs_pkg::PAY_W-1:0]           entry_payload_i,
  input  stbs_pkg::dp_cmd_t                    cmd_i,
  output stbs_pkg::dp_status_t                 status_o,
  output logic                                 found_o,
  output logic [stbs_pkg::PAY_W-1:0]           match_payload_o,
  output logic [stbs_pkg::IDX_W-1:0]           match_position_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BW = stbs_pkg::BND_W;
  localparam int IW = stbs_pkg::IDX_W;
  localparam int EW = (AW > IW) ? AW : IW;
  localparam int PW = (AW > BW) ? AW : BW;

  logic signed [stbs_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [stbs_pkg::PAY_W-1:0]        pay_mem [TABLE_DEPTH];

  logic [stbs_pkg::SIZE_W-1:0]       size_q;
  logic [BW-1:0]                     size_sat;
  logic signed [stbs_pkg::KEY_W-1:0] key_q;
  logic signed [stbs_pkg::KEY_W-1:0] rd_key_q;
  logic [stbs_pkg::PAY_W-1:0]        rd_pay_q;
  logic [BW-1:0]                     lo_q, lo_d;
  logic [BW-1:0]                     hx_q, hx_d;
  logic [BW-1:0]                     mid_q, mid_d;
  logic [BW-1:0]                     step_lo, step_hx;
  logic [BW-1:0]                     span;
  logic                              greater;
  logic                              rd_en;
  logic [PW-1:0]                     rd_ext;
  logic [AW-1:0]                     rd_addr;
  logic [EW-1:0]                     wr_ext;
  logic [AW-1:0]                     wr_addr;
  logic                              wr_ok;
  logic                              found_q;
  logic [stbs_pkg::PAY_W-1:0]        res_pay_q;
  logic [IW-1:0]                     res_pos_q;

  assign size_sat = (32'(size_q) > 32'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH) : size_q;

  assign greater = rd_key_q > key_q;
  assign step_lo = greater ? lo_q : (mid_q + BW'(1));
  assign step_hx = greater ? mid_q : hx_q;

  always_comb begin
    lo_d = lo_q;
    hx_d = hx_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hx_d = size_sat;
    end else if (cmd_i.step) begin
      lo_d = step_lo;
      hx_d = step_hx;
    end
  end

  assign span  = hx_d - lo_d - BW'(1);
  assign mid_d = lo_d + (span >> 1);

  assign status_o.init_nonempty = (size_sat != '0);
  assign status_o.step_nonempty = (step_hx > step_lo);
  assign status_o.equal         = (rd_key_q == key_q);

  assign rd_en   = (cmd_i.load && status_o.init_nonempty) ||
                   (cmd_i.step && status_o.step_nonempty && !status_o.equal);
  assign rd_ext  = PW'(mid_d);
  assign rd_addr = rd_ext[AW-1:0];
  assign wr_ext  = EW'(entry_index_i);
  assign wr_addr = wr_ext[AW-1:0];
  assign wr_ok   = (32'(entry_index_i) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_ok) begin
      key_mem[wr_addr] <= search_key_i;
      pay_mem[wr_addr] <= entry_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_pay_q <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= search_key_i;
    end
    if (cmd_i.hit) begin
      res_pay_q <= rd_pay_q;
      res_pos_q <= mid_q[IW-1:0];
    end else if (cmd_i.miss) begin
      res_pay_q <= '0;
      res_pos_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= '0;
      lo_q    <= '0;
      hx_q    <= '0;
      mid_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (cmd_i.load || cmd_i.step) begin
        lo_q  <= lo_d;
        hx_q  <= hx_d;
        mid_q <= mid_d;
      end
      if (cmd_i.hit) begin
        found_q <= 1'b1;
      end else if (cmd_i.miss) begin
        found_q <= 1'b0;
      end
    end
  end

  assign found_o          = found_q;
  assign match_payload_o  = res_pay_q;
  assign match_position_o = res_pos_q;

  a_probe_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (mid_q >= lo_q && mid_q < hx_q && hx_q <= size_sat))
    else $error("probe position outside the search window");

endmodule

[tb/sorted_table_binary_search_tb.sv]
// Self-checking testbench for the sorted table binary search block.
`timescale 1ns / 1ps
module sorted_table_binary_search_tb;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic                              opcode;
    logic [stbs_pkg::IDX_W-1:0]        index;
    logic signed [stbs_pkg::KEY_W-1:0] key;
    logic [stbs_pkg::PAY_W-1:0]        payload;
  } table_request_t;

  typedef struct packed {
    logic                       found;
    logic [stbs_pkg::PAY_W-1:0] payload;
    logic [stbs_pkg::IDX_W-1:0] position;
  } lookup_answer_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [stbs_pkg::SIZE_W-1:0]       cfg_wdata_i = '0;
  logic                              start_i = 1'b0;
  logic                              busy_o;
  logic                              opcode_i = stbs_pkg::OP_WRITE;
  logic [stbs_pkg::IDX_W-1:0]        entry_index_i = '0;
  logic signed [stbs_pkg::KEY_W-1:0] search_key_i = '0;
  logic [stbs_pkg::PAY_W-1:0]        entry_payload_i = '0;
  logic                              done_o;
  logic                              found_o;
  logic [stbs_pkg::PAY_W-1:0]        match_payload_o;
  logic [stbs_pkg::IDX_W-1:0]        match_position_o;

  logic signed [stbs_pkg::KEY_W-1:0] key_mirror [DEPTH];
  logic [stbs_pkg::PAY_W-1:0]        payload_mirror [DEPTH];
  logic [stbs_pkg::SIZE_W-1:0]       size_mirror = '0;
  lookup_answer_t                    answers_due [$];

  int errors = 0;
  int items_sent = 0;
  int writes_sent = 0;
  int lookups_sent = 0;
  int hits_seen = 0;
  int sender_idle_pct = 0;

  sorted_table_binary_search #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .entry_index_i    (entry_index_i),
    .search_key_i     (search_key_i),
    .entry_payload_i  (entry_payload_i),
    .done_o           (done_o),
    .found_o          (found_o),
    .match_payload_o  (match_payload_o),
    .match_position_o (match_position_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int active_entries();
    return (size_mirror > DEPTH) ? DEPTH : int'(size_mirror);
  endfunction

  function automatic lookup_answer_t predict_answer(table_request_t req);
    lookup_answer_t                    ans;
    logic signed [stbs_pkg::KEY_W-1:0] want;
    int                                lo;
    int                                hi;
    int                                mid;
    ans = '0;
    want = req.key;
    if (req.opcode == stbs_pkg::OP_WRITE) begin
      key_mirror[req.index] = want;
      payload_mirror[req.index] = req.payload;
      return ans;
    end
    lo = 0;
    hi = active_entries() - 1;
    while (hi >= lo) begin
      mid = lo + (hi - lo) / 2;
      if (key_mirror[mid] == want) begin
        ans.found = 1'b1;
        ans.payload = payload_mirror[mid];
        ans.position = mid[stbs_pkg::IDX_W-1:0];
        return ans;
      end
      if (key_mirror[mid] > want) hi = mid - 1;
      else lo = mid + 1;
    end
    return ans;
  endfunction

  task automatic send_request(input table_request_t req);
    opcode_i        <= req.opcode;
    entry_index_i   <= req.index;
    search_key_i    <= req.key;
    entry_payload_i <= req.payload;
    start_i         <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    answers_due.push_back(predict_answer(req));
    items_sent++;
    if (req.opcode == stbs_pkg::OP_WRITE) writes_sent++;
    else lookups_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic write_entry(input int idx, input logic [stbs_pkg::KEY_W-1:0] key,
                             input logic [stbs_pkg::PAY_W-1:0] pay);
    table_request_t req;
    req.opcode = stbs_pkg::OP_WRITE;
    req.index = idx[stbs_pkg::IDX_W-1:0];
    req.key = key;
    req.payload = pay;
    send_request(req);
  endtask

  task automatic lookup_key(input logic [stbs_pkg::KEY_W-1:0] key);
    table_request_t req;
    req.opcode = stbs_pkg::OP_LOOKUP;
    req.index = stbs_pkg::IDX_W'($urandom);
    req.key = key;
    req.payload = $urandom;
    send_request(req);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_table_size(input int value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[stbs_pkg::SIZE_W-1:0];
    @(posedge clk_i);
    size_mirror = value[stbs_pkg::SIZE_W-1:0];
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_empty_table_after_reset();
    lookup_key(32'sh0000_0000);
    lookup_key(32'sh8000_0000);
  endtask

  task automatic test_load_directed_table();
    logic [stbs_pkg::KEY_W-1:0] key;
    logic [stbs_pkg::PAY_W-1:0] pay;
    for (int i = 0; i < DEPTH; i++) begin
      key = (i == 0) ? 32'sh8000_0000 : (i == DEPTH - 1) ? 32'sh7FFF_FFFF : (i - 7) * 1000;
      pay = (i == 0) ? 32'h0000_0000 : (i == DEPTH - 1) ? 32'hFFFF_FFFF : 32'hA5A5_0000 + i;
      write_entry(i, key, pay);
    end
    set_table_size(16);
  endtask

  task automatic test_directed_lookups();
    lookup_key(32'sh8000_0000);
    lookup_key(32'sh7FFF_FFFF);
    lookup_key(32'sh8000_0001);
    lookup_key(500);
    lookup_key(32'sh7FFF_FFFE);
  endtask

  task automatic test_table_size_extremes();
    set_table_size(31);
    lookup_key(32'sh7FFF_FFFF);
    set_table_size(17);
    lookup_key(32'sh8000_0000);
    set_table_size(1);
    lookup_key(32'sh8000_0000);
    lookup_key(32'sh7FFF_FFFF);
    set_table_size(0);
    lookup_key(32'sh8000_0000);
    set_table_size(16);
  endtask

  task automatic test_unsorted_and_duplicate_keys();
    write_entry(3, 0, 32'h1234_5678);
    lookup_key(0);
    write_entry(12, 32'sh8000_0000, 32'h8765_4321);
    lookup_key(32'sh8000_0000);
  endtask

  task automatic load_sorted_table();
    int  keys [DEPTH];
    int  v;
    int  j;
    int  first;
    bit  narrow;
    narrow = ($urandom_range(7) == 0);
    for (int i = 0; i < DEPTH; i++) keys[i] = narrow ? $urandom_range(16) - 8 : $urandom;
    for (int i = 1; i < DEPTH; i++) begin
      v = keys[i];
      j = i - 1;
      while (j >= 0 && keys[j] > v) begin
        keys[j + 1] = keys[j];
        j--;
      end
      keys[j + 1] = v;
    end
    if ($urandom_range(5) == 0) keys[$urandom_range(DEPTH - 1)] = $urandom;
    first = $urandom_range(DEPTH - 1);
    for (int i = 0; i < DEPTH; i++) begin
      j = (first + i) % DEPTH;
      write_entry(j, keys[j], $urandom);
    end
  endtask

  task automatic test_random_traffic(input int budget);
    int target;
    int n;
    int r;
    int pick;
    target = items_sent + budget;
    while (items_sent < target) begin
      if ($urandom_range(3) == 0) load_sorted_table();
      r = $urandom_range(9);
      set_table_size((r == 0) ? 0 : (r == 1) ? $urandom_range(17, 31) : $urandom_range(1, 16));
      n = active_entries();
      repeat ($urandom_range(15, 25)) begin
        r = $urandom_range(99);
        if (r < 80) begin
          r = $urandom_range(99);
          pick = (n > 0) ? $urandom_range(n - 1) : 0;
          if (n > 0 && r < 60) lookup_key(key_mirror[pick]);
          else if (n > 0 && r < 80) lookup_key(key_mirror[pick] + ($urandom_range(1) ? 1 : -1));
          else lookup_key($urandom);
        end else begin
          pick = $urandom_range(DEPTH - 1);
          if ($urandom_range(1)) write_entry(pick, key_mirror[pick], $urandom);
          else write_entry(pick, $urandom, $urandom);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : check_answers
    lookup_answer_t want_ans;
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want_ans = answers_due.pop_front();
        if (found_o !== want_ans.found) begin
          $error("found: expected %0d, got %0d", want_ans.found, found_o);
          errors++;
        end
        if (match_payload_o !== want_ans.payload) begin
          $error("match_payload: expected %08h, got %08h", want_ans.payload, match_payload_o);
          errors++;
        end
        if (match_position_o !== want_ans.position) begin
          $error("match_position: expected %0d, got %0d", want_ans.position, match_position_o);
          errors++;
        end
        if (want_ans.found) hits_seen++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int drain;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table_after_reset();
    test_load_directed_table();
    test_directed_lookups();
    test_table_size_extremes();
    test_unsorted_and_duplicate_keys();
    sender_idle_pct = 8;
    test_random_traffic(230);
    sender_idle_pct = 70;
    test_random_traffic(230);
    sender_idle_pct = 0;
    test_random_traffic(230);
    start_i <= 1'b0;
    drain = 0;
    while (answers_due.size() != 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (answers_due.size() != 0) begin
      $error("%0d results never arrived", answers_due.size());
      errors++;
    end
    $display("Run covered %0d table writes and %0d lookups, %0d of them hits,",
             writes_sent, lookups_sent, hits_seen);
    $display("over table sizes 0 to 31 with sender gaps of 8, 70 and 0 percent.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/stbs_pkg.sv
hdl/stbs_ctrl.sv
hdl/stbs_datapath.sv
hdl/sorted_table_binary_search.sv
tb/sorted_table_binary_search_tb.sv
